@@ hdl/dssm_pkg.sv @@
package dssm_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH1 = 3'd0,
    OP_PUSH2 = 3'd1,
    OP_POP1  = 3'd2,
    OP_POP2  = 3'd3,
    OP_DISP1 = 3'd4,
    OP_DISP2 = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] data_word;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic    capture;
    logic    push;
    logic    pop_start;
    logic    walk_step;
    logic    emit_word;
    logic    emit_code;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       final_word;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ hdl/dssm_in_if.sv @@
interface dssm_in_if;
  import dssm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ hdl/dssm_out_if.sv @@
interface dssm_out_if;
  import dssm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ hdl/dssm_ctrl.sv @@
module dssm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dssm_pkg::dp_sts_t sts,
  output dssm_pkg::dp_cmd_t cmd
);
  import dssm_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (opcode_t'(sts.op))
          OP_PUSH1, OP_PUSH2: begin
            if (sts.out_free) begin
              state_next = S_IDLE;
            end
          end
          OP_POP1, OP_POP2, OP_DISP1, OP_DISP2: begin
            if (!sts.empty) begin
              state_next = S_EMIT;
            end else if (sts.out_free) begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (sts.out_free && sts.final_word) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.code = ST_OK;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = accept;
      end
      S_EXEC: begin
        unique case (opcode_t'(sts.op))
          OP_PUSH1, OP_PUSH2: begin
            if (sts.out_free) begin
              cmd.emit_code = 1'b1;
              cmd.push      = !sts.full;
              cmd.code      = sts.full ? ST_FULL : ST_OK;
            end
          end
          OP_POP1, OP_POP2, OP_DISP1, OP_DISP2: begin
            if (!sts.empty) begin
              cmd.pop_start = 1'b1;
            end else if (sts.out_free) begin
              cmd.emit_code = 1'b1;
              cmd.code      = ST_EMPTY;
            end
          end
          default: cmd = '0;
        endcase
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_word = 1'b1;
          cmd.walk_step = !sts.final_word;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/dssm_datapath.sv @@
module dssm_datapath #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  dssm_pkg::in_item_t  in_item,
  input  dssm_pkg::dp_cmd_t   cmd,
  output dssm_pkg::dp_sts_t   sts,
  output logic                out_valid,
  output dssm_pkg::out_item_t out_item,
  input  logic                out_ready
);
  import dssm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [2:0]        op;
  logic [WORD_W-1:0] value;
  logic [CW-1:0]     lower;
  logic [CW-1:0]     upper;
  logic [AW-1:0]     addr;
  logic [WORD_W-1:0] rd_data;

  logic              side;
  logic [CW:0]       used;
  logic [CW-1:0]     lower_top;
  logic [CW-1:0]     upper_top;
  logic [CW-1:0]     upper_free;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     step_addr;
  logic [AW-1:0]     rd_addr;
  logic              at_end;
  logic              out_free;

  assign side       = op[0];
  assign used       = {1'b0, lower} + {1'b0, upper};
  assign lower_top  = lower - CW'(1);
  assign upper_top  = DEPTH_C - upper;
  assign upper_free = upper_top - CW'(1);
  assign wr_addr    = side ? upper_free[AW-1:0] : lower[AW-1:0];
  assign top_addr   = side ? upper_top[AW-1:0] : lower_top[AW-1:0];
  assign step_addr  = side ? addr + AW'(1) : addr - AW'(1);
  assign rd_addr    = cmd.pop_start ? top_addr : step_addr;
  assign at_end     = side ? (addr == ADDR_TOP) : (addr == '0);
  assign out_free   = !out_valid || out_ready;

  assign sts.op         = op;
  assign sts.full       = used >= {1'b0, DEPTH_C};
  assign sts.empty      = side ? (upper == '0) : (lower == '0);
  assign sts.final_word = !op[2] || at_end;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= in_item.opcode;
      value <= in_item.push_value;
    end
    if (cmd.pop_start) begin
      addr <= top_addr;
    end else if (cmd.walk_step) begin
      addr <= step_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= value;
    end
    if (cmd.pop_start || cmd.walk_step) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower <= '0;
      upper <= '0;
    end else if (cmd.push) begin
      if (side) begin
        upper <= upper + CW'(1);
      end else begin
        lower <= lower + CW'(1);
      end
    end else if (cmd.pop_start && !op[2]) begin
      if (side) begin
        upper <= upper - CW'(1);
      end else begin
        lower <= lower - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_word || cmd.emit_code) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_word) begin
      out_item.status    <= ST_OK;
      out_item.data_word <= rd_data;
      out_item.last      <= sts.final_word;
    end else if (cmd.emit_code) begin
      out_item.status    <= cmd.code;
      out_item.data_word <= '0;
      out_item.last      <= 1'b1;
    end
  end

endmodule

@@ hdl/dual_stack_shared_memory.sv @@
// Channel  Direction  Payload                          Handshake
// cmd      in         opcode, push_value               valid / ready
// rsp      out        status, data_word, last          valid / ready
//
// One transaction at a time: accepted in IDLE, decided in EXEC.
// Push, full and empty answers are issued from EXEC; pop and display words pass
// through the registered read of the shared word array and are emitted in EMIT.
// Display emits one word per cycle from the read port while rsp is not stalled.
// Reset clears both stack counts and the output valid flag; the array and output item are not cleared.
// A stalled rsp holds its result; cmd is taken again once the last result is loaded.
module dual_stack_shared_memory #(
  parameter int DEPTH = dssm_pkg::DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  dssm_in_if.sink   cmd,
  dssm_out_if.source rsp
);
  import dssm_pkg::*;

  dp_cmd_t   dp_cmd;
  dp_sts_t   dp_sts;
  logic      out_valid;
  out_item_t out_item;
  logic      in_ready;

  dssm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  dssm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (cmd.item),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (rsp.ready)
  );

  assign cmd.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.item  = out_item;

endmodule

@@ hdl/dssm_checker.sv @@
module dssm_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input dssm_pkg::out_item_t rsp_item
);
  import dssm_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("rsp result changed while stalled");

  a_code_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status != ST_OK |-> rsp_item.data_word == '0 && rsp_item.last)
    else $error("full or empty result carries data or is not last");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd taken again before the transaction was decided");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_item.status == ST_OK || rsp_item.status == ST_FULL ||
                  rsp_item.status == ST_EMPTY)
    else $error("rsp status code out of range");

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_item  (rsp.item)
);

@@ tb/dual_stack_shared_memory_test.sv @@
module dual_stack_shared_memory_test;
  import dssm_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 320;
  localparam int IDLE_PCT = 36;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  class stack_scoreboard;
    logic [WORD_W-1:0] words [DEPTH];
    int unsigned       lower_fill;
    int unsigned       upper_fill;
    out_item_t         due_q [$];
    int                errors;
    int                checked;
    int                full_answers;
    int                empty_answers;
    int                longest_walk;

    function new();
      lower_fill = 0;
      upper_fill = 0;
      errors = 0;
      checked = 0;
      full_answers = 0;
      empty_answers = 0;
      longest_walk = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void queue_rsp(status_t st, logic [WORD_W-1:0] word, logic fin);
      out_item_t r;
      r.status = st;
      r.data_word = word;
      r.last = fin;
      due_q.push_back(r);
    endfunction

    function void note_cmd(in_item_t it);
      int unsigned i;
      case (it.opcode)
        OP_PUSH1, OP_PUSH2: begin
          if (lower_fill + upper_fill >= DEPTH) begin
            queue_rsp(ST_FULL, '0, 1'b1);
            full_answers++;
          end else begin
            if (it.opcode == OP_PUSH1) begin
              words[lower_fill] = it.push_value;
              lower_fill++;
            end else begin
              upper_fill++;
              words[DEPTH - upper_fill] = it.push_value;
            end
            queue_rsp(ST_OK, '0, 1'b1);
          end
        end
        OP_POP1: begin
          if (lower_fill == 0) begin
            queue_rsp(ST_EMPTY, '0, 1'b1);
            empty_answers++;
          end else begin
            lower_fill--;
            queue_rsp(ST_OK, words[lower_fill], 1'b1);
          end
        end
        OP_POP2: begin
          if (upper_fill == 0) begin
            queue_rsp(ST_EMPTY, '0, 1'b1);
            empty_answers++;
          end else begin
            queue_rsp(ST_OK, words[DEPTH - upper_fill], 1'b1);
            upper_fill--;
          end
        end
        OP_DISP1: begin
          if (lower_fill == 0) begin
            queue_rsp(ST_EMPTY, '0, 1'b1);
            empty_answers++;
          end else begin
            for (i = lower_fill; i > 0; i--) queue_rsp(ST_OK, words[i-1], i == 1);
            if (lower_fill > longest_walk) longest_walk = lower_fill;
          end
        end
        OP_DISP2: begin
          if (upper_fill == 0) begin
            queue_rsp(ST_EMPTY, '0, 1'b1);
            empty_answers++;
          end else begin
            for (i = DEPTH - upper_fill; i < DEPTH; i++) begin
              queue_rsp(ST_OK, words[i], i == DEPTH - 1);
            end
            if (upper_fill > longest_walk) longest_walk = upper_fill;
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report(string msg);
      $display("%0t: rsp transaction %0d: %s", $realtime, checked, msg);
      errors++;
    endtask

    task check_rsp(out_item_t got);
      out_item_t want;
      if (due_q.size() == 0) begin
        report("result with nothing pending");
      end else begin
        want = due_q.pop_front();
        if (got.status !== want.status) begin
          report($sformatf("status %0d, want %0d", got.status, want.status));
        end
        if (got.data_word !== want.data_word) begin
          report($sformatf("data_word %h, want %h", got.data_word, want.data_word));
        end
        if (got.last !== want.last) begin
          report($sformatf("last %b, want %b", got.last, want.last));
        end
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady = 1'b0;
  int   cycles = 0;
  int   work_items = 0;
  int   spare_items = 0;

  stack_scoreboard sb;

  dssm_in_if  cmd_ch ();
  dssm_out_if rsp_ch ();

  dual_stack_shared_memory #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dual_stack_shared_memory: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_rsp(rsp_ch.item);
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_cmd(input logic [2:0] op, input logic [WORD_W-1:0] value);
    in_item_t it;
    it.opcode = op;
    it.push_value = value;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.item <= it;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_cmd(it);
    if (op == OP_SPARE6 || op == OP_SPARE7) begin
      spare_items++;
    end else begin
      work_items++;
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    logic [WORD_W-1:0] edges [4];
    edges[0] = 32'h7FFF_FFFF;
    edges[1] = 32'h8000_0000;
    edges[2] = 32'h0000_0000;
    edges[3] = 32'hFFFF_FFFF;
    if ($urandom_range(0, 99) < 10) return edges[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // mode 0 favors pushes, mode 1 favors pops, mode 2 is balanced
  function automatic logic [2:0] pick_op(int mode);
    int r;
    int push_top;
    int pop_top;
    logic side;
    r = $urandom_range(0, 99);
    side = 1'($urandom_range(0, 1));
    push_top = (mode == 0) ? 73 : (mode == 1) ? 28 : 48;
    pop_top = (mode == 0) ? 93 : 88;
    if (r < 3) return side ? OP_SPARE7 : OP_SPARE6;
    if (r < push_top) return side ? OP_PUSH2 : OP_PUSH1;
    if (r < pop_top) return side ? OP_POP2 : OP_POP1;
    return side ? OP_DISP2 : OP_DISP1;
  endfunction

  initial begin
    int k;
    int mode;
    int phase_left;
    int directed_items;
    logic [WORD_W-1:0] edge_words [4];
    sb = new();
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.item = '0;
    edge_words[0] = 32'h7FFF_FFFF;
    edge_words[1] = 32'h8000_0000;
    edge_words[2] = 32'h0000_0000;
    edge_words[3] = 32'hFFFF_FFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_cmd(OP_POP1, 32'h0);
    send_cmd(OP_POP2, 32'hFFFF_FFFF);
    send_cmd(OP_DISP1, 32'h0);
    send_cmd(OP_DISP2, 32'h0);
    for (k = 0; k < DEPTH; k++) begin
      send_cmd(k[0] ? OP_PUSH2 : OP_PUSH1, (k < 4) ? edge_words[k] : $urandom);
    end
    send_cmd(OP_PUSH1, 32'h1234_5678);
    send_cmd(OP_PUSH2, 32'h8765_4321);
    send_cmd(OP_DISP1, 32'h0);
    send_cmd(OP_DISP2, 32'h0);
    send_cmd(OP_SPARE6, 32'hFFFF_FFFF);
    send_cmd(OP_SPARE7, 32'h5555_AAAA);
    send_cmd(OP_POP1, 32'h0);
    send_cmd(OP_POP2, 32'h0);
    directed_items = work_items;

    mode = 0;
    phase_left = 0;
    while (work_items < directed_items + RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        mode = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 50);
      end
      steady = (work_items >= directed_items + 140) && (work_items < directed_items + 220);
      send_cmd(pick_op(mode), pick_value());
      phase_left--;
    end
    cmd_ch.valid <= 1'b0;
    steady = 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("Ran %0d stack transactions (%0d ignored codes), checked %0d results.",
             work_items, spare_items, sb.checked);
    $display("Full answers: %0d, empty answers: %0d, longest display: %0d words.",
             sb.full_answers, sb.empty_answers, sb.longest_walk);
    if (sb.errors == 0) begin
      $display("dual_stack_shared_memory: match");
    end else begin
      $display("dual_stack_shared_memory: mismatch");
    end
    $finish;
  end

endmodule
